// ----- design/decimal_digit_sprite_mapper_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the digit sprite mapper
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_DIGIT_SPRITE_MAPPER_UNIT_MACROS_SVH
`define DECIMAL_DIGIT_SPRITE_MAPPER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every edge out of reset
`define DDSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// cause at one edge implies effect at the next
`define DDSM_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error(msg);

`else

`define DDSM_ASSERT(lbl, prop, msg)
`define DDSM_ASSERT_NEXT(lbl, cause, effect, msg)

`endif

`endif

// ----- design/ddsm_pkg.sv -----
// ----------------------------------------------------------------------------
// ddsm_pkg
// Widths, constants and types shared by the digit sprite mapper files.
// ----------------------------------------------------------------------------
package ddsm_pkg;

  // number format
  localparam int unsigned VALUE_BITS     = 32;
  localparam int unsigned MAX_DIGITS     = 8;
  localparam int unsigned BCD_DIGITS     = 10;  // decimal digits of a 32-bit value
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned BCD_BITS       = BCD_DIGITS * DIGIT_W;

  // conversion pipeline: bits shifted in per stage
  localparam int unsigned BITS_PER_STAGE = 4;
  localparam int unsigned NUM_STAGES     = VALUE_BITS / BITS_PER_STAGE;

  // field widths
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned PTR_W      = $clog2(BCD_DIGITS);
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned ORG_W      = 12;
  localparam int unsigned SRCX_W     = 12;
  localparam int unsigned SRCY_W     = 9;
  localparam int unsigned DSTX_W     = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // font sheet layout: glyph columns counted in cells from the sheet edge
  localparam int unsigned GLYPH_BASE_CELLS = 7;
  localparam int unsigned NINE_CELLS       = 8;   // glyph of nine
  localparam int unsigned ZERO_CELLS       = 9;   // glyph of zero
  localparam int unsigned LAST_MID_DIGIT   = 8;
  localparam int unsigned NINE_DIGIT       = 9;

  // register reset values
  localparam logic [CNT_W-1:0]  RST_DIGIT_COUNT = CNT_W'(3);
  localparam logic [CELL_W-1:0] RST_CELL_WIDTH  = CELL_W'(16);
  localparam logic [CELL_W-1:0] RST_CELL_HEIGHT = CELL_W'(16);
  localparam logic [ORG_W-1:0]  RST_ORIGIN_X    = '0;
  localparam logic [ORG_W-1:0]  RST_ORIGIN_Y    = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIGIT_COUNT = 3'd0,
    REG_CELL_WIDTH  = 3'd1,
    REG_CELL_HEIGHT = 3'd2,
    REG_ORIGIN_X    = 3'd3,
    REG_ORIGIN_Y    = 3'd4
  } cfg_reg_e;

  typedef logic [BCD_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

endpackage

// ----- design/ddsm_if.sv -----
// ----------------------------------------------------------------------------
// ddsm_if
// Valid/ready channels of the digit sprite mapper: number in, glyph out.
// ----------------------------------------------------------------------------
interface ddsm_in_if;
  import ddsm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ddsm_out_if;
  import ddsm_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic [SLOT_W-1:0]  slot;
  logic [SRCX_W-1:0]  source_x;
  logic [SRCY_W-1:0]  source_y;
  logic [DSTX_W-1:0]  dest_x;
  logic [ORG_W-1:0]   dest_y;
  logic               last;

  modport source (output valid, output digit, output slot, output source_x,
                  output source_y, output dest_x, output dest_y, output last,
                  input ready);
  modport sink   (input valid, input digit, input slot, input source_x,
                  input source_y, input dest_x, input dest_y, input last,
                  output ready);
endinterface

// ----- design/ddsm_dabble.sv -----
// ----------------------------------------------------------------------------
// ddsm_dabble
// Pipelined binary to BCD conversion (shift and add-3), a few bits per stage.
// ----------------------------------------------------------------------------
module ddsm_dabble
  import ddsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] in_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bcd_t                  out_bcd_o
);

  localparam int unsigned WORD_W = BCD_BITS + VALUE_BITS;
  typedef logic [WORD_W-1:0] word_t;

  // one shift step: correct every BCD digit, then shift in the next binary bit
  function automatic word_t dabble_bit(word_t w);
    word_t r;
    r = w;
    for (int unsigned k = 0; k < BCD_DIGITS; k++) begin
      if (r[VALUE_BITS + DIGIT_W*k +: DIGIT_W] >= DIGIT_W'(5)) begin
        r[VALUE_BITS + DIGIT_W*k +: DIGIT_W] =
          r[VALUE_BITS + DIGIT_W*k +: DIGIT_W] + DIGIT_W'(3);
      end
    end
    return {r[WORD_W-2:0], 1'b0};
  endfunction

  word_t [NUM_STAGES-1:0] word_q, word_d;
  logic  [NUM_STAGES-1:0] vld_q, vld_d;
  logic                   advance;

  // whole pipe moves unless the tail holds an item nobody takes
  assign advance = !vld_q[NUM_STAGES-1] || out_ready_i;

  // stage datapath
  always_comb begin
    word_t w;
    w = {{BCD_BITS{1'b0}}, in_value_i};
    for (int unsigned b = 0; b < BITS_PER_STAGE; b++) begin
      w = dabble_bit(w);
    end
    word_d[0] = w;
    vld_d[0]  = in_valid_i;
    for (int unsigned j = 1; j < NUM_STAGES; j++) begin
      w = word_q[j-1];
      for (int unsigned b = 0; b < BITS_PER_STAGE; b++) begin
        w = dabble_bit(w);
      end
      word_d[j] = w;
      vld_d[j]  = vld_q[j-1];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= vld_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      word_q <= word_d;
    end
  end

  assign in_ready_o  = advance;
  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign out_bcd_o   = word_q[NUM_STAGES-1][WORD_W-1 -: BCD_BITS];

endmodule

// ----- design/decimal_digit_sprite_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// decimal_digit_sprite_mapper_unit
// Splits a number into display digits and maps each to its glyph and place.
// ----------------------------------------------------------------------------
// Pipeline: 8 conversion stages (the first loads at the input transfer), the
//   emitter load register and 1 output register; after the first digit, one
//   digit a cycle while the output is taken.
// Emitter: the digit emitter holds one number until all n of its digits are
//   emitted, n being the digit count clamped to 1..8, and takes no new number meanwhile.
// Reset: registers return to 3 digits, 16x16 cells, origin 0; pipe empties.
// ----------------------------------------------------------------------------
`include "decimal_digit_sprite_mapper_unit_macros.svh"

module decimal_digit_sprite_mapper_unit
  import ddsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ddsm_in_if.sink               in_i,
  ddsm_out_if.source            out_o
);

  typedef struct packed {
    logic [CNT_W-1:0]  digit_count;
    logic [CELL_W-1:0] cell_width;
    logic [CELL_W-1:0] cell_height;
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_y;
  } cfg_t;

  cfg_t cfg_q, cfg_d;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DIGIT_COUNT: cfg_d.digit_count = cfg_wdata_i[CNT_W-1:0];
        REG_CELL_WIDTH:  cfg_d.cell_width  = cfg_wdata_i[CELL_W-1:0];
        REG_CELL_HEIGHT: cfg_d.cell_height = cfg_wdata_i[CELL_W-1:0];
        REG_ORIGIN_X:    cfg_d.origin_x    = cfg_wdata_i[ORG_W-1:0];
        REG_ORIGIN_Y:    cfg_d.origin_y    = cfg_wdata_i[ORG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{digit_count: RST_DIGIT_COUNT, cell_width: RST_CELL_WIDTH,
                 cell_height: RST_CELL_HEIGHT, origin_x: RST_ORIGIN_X,
                 origin_y: RST_ORIGIN_Y};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // digits shown, clamped to 1..MAX_DIGITS
  logic [CNT_W-1:0] n_eff;
  always_comb begin
    n_eff = cfg_q.digit_count;
    if (cfg_q.digit_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_q.digit_count > CNT_W'(MAX_DIGITS)) begin
      n_eff = CNT_W'(MAX_DIGITS);
    end
  end

  // conversion pipeline
  logic tail_valid, tail_ready;
  bcd_t tail_bcd;

  ddsm_dabble u_dabble (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_value_i (in_i.value),
    .out_valid_o(tail_valid),
    .out_ready_i(tail_ready),
    .out_bcd_o  (tail_bcd)
  );

  // leading digit search: start at the top nonzero digit when it overflows
  logic [PTR_W-1:0] msd, start;
  logic             nonzero;
  always_comb begin
    msd     = '0;
    nonzero = 1'b0;
    for (int unsigned k = 0; k < BCD_DIGITS; k++) begin
      if (tail_bcd[k] != '0) begin
        msd     = PTR_W'(k);
        nonzero = 1'b1;
      end
    end
    if (nonzero && (CNT_W'(msd) >= n_eff)) begin
      start = msd;
    end else begin
      start = PTR_W'(n_eff - CNT_W'(1));
    end
  end

  // digit emitter
  logic             busy_q, busy_d;
  bcd_t             bcd_q, bcd_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic             load, out_load, last_emit;

  assign tail_ready = !busy_q;
  assign load       = tail_valid && !busy_q;
  assign out_load   = busy_q && (!out_o.valid || out_o.ready);
  assign last_emit  = (CNT_W'(cnt_q) == (n_eff - CNT_W'(1)));

  always_comb begin
    busy_d = busy_q;
    bcd_d  = bcd_q;
    ptr_d  = ptr_q;
    cnt_d  = cnt_q;
    if (load) begin
      busy_d = 1'b1;
      bcd_d  = tail_bcd;
      ptr_d  = start;
      cnt_d  = '0;
    end else if (out_load) begin
      busy_d = !last_emit;
      ptr_d  = ptr_q - PTR_W'(1);
      cnt_d  = cnt_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    ptr_q <= ptr_d;
  end

  // glyph and screen placement of the current digit
  logic [DIGIT_W-1:0] cur_digit;
  logic               mid;
  logic [DIGIT_W-1:0] glyph_cells;
  logic [SRCX_W-1:0]  src_x;
  logic [SRCY_W-1:0]  src_y;
  logic [DSTX_W-1:0]  dst_x;

  always_comb begin
    cur_digit = bcd_q[ptr_q];
    mid = (cur_digit != '0) && (cur_digit <= DIGIT_W'(LAST_MID_DIGIT));
    if (mid) begin
      glyph_cells = DIGIT_W'(GLYPH_BASE_CELLS) + cur_digit;
    end else if (cur_digit == DIGIT_W'(NINE_DIGIT)) begin
      glyph_cells = DIGIT_W'(NINE_CELLS);
    end else begin
      glyph_cells = DIGIT_W'(ZERO_CELLS);
    end
    src_x = SRCX_W'(glyph_cells) * SRCX_W'(cfg_q.cell_width) + SRCX_W'(1);
    src_y = mid ? {1'b0, cfg_q.cell_height} : {cfg_q.cell_height, 1'b0};
    dst_x = DSTX_W'(cfg_q.origin_x) + DSTX_W'(cnt_q) * DSTX_W'(cfg_q.cell_width);
  end

  // output register
  logic               out_valid_q;
  logic [DIGIT_W-1:0] digit_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [SRCX_W-1:0]  src_x_q;
  logic [SRCY_W-1:0]  src_y_q;
  logic [DSTX_W-1:0]  dst_x_q;
  logic [ORG_W-1:0]   dst_y_q;
  logic               last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      digit_q <= cur_digit;
      slot_q  <= cnt_q;
      src_x_q <= src_x;
      src_y_q <= src_y;
      dst_x_q <= dst_x;
      dst_y_q <= cfg_q.origin_y;
      last_q  <= last_emit;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.digit    = digit_q;
  assign out_o.slot     = slot_q;
  assign out_o.source_x = src_x_q;
  assign out_o.source_y = src_y_q;
  assign out_o.dest_x   = dst_x_q;
  assign out_o.dest_y   = dst_y_q;
  assign out_o.last     = last_q;

  // checks
  `DDSM_ASSERT(a_ptr_range, !busy_q || (ptr_q <= PTR_W'(BCD_DIGITS - 1)), "digit pointer out of range")
  `DDSM_ASSERT(a_cnt_range, !busy_q || (CNT_W'(cnt_q) < n_eff), "slot count past digit count")
  `DDSM_ASSERT_NEXT(a_done, out_load && last_emit, !busy_q, "emitter busy after last digit")
  `DDSM_ASSERT_NEXT(a_load, load, busy_q && (cnt_q == '0), "emitter load did not start at slot zero")

endmodule
